[src/brz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brz_pkg: shared types and constants for the bilinear resize unit
// Sizes of the source store, field widths, configuration and queue item types.
// ----------------------------------------------------------------------------
package brz_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 4;

    localparam int COORD_W  = 8;
    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 8;
    localparam int SIZE_W   = 9;
    localparam int RATIO_W  = 25;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = SIZE_W + RATIO_W;
    localparam int POS_W    = PROD_W + 1;
    localparam int INT_W    = POS_W - FRAC_W + 1;
    localparam int WGT_W    = FRAC_W + 1;
    localparam int ROW_W    = SAMPLE_W + WGT_W;
    localparam int BLEND_W  = ROW_W + WGT_W;

    // four banks by row and column parity
    localparam int NUM_BANKS  = 4;
    localparam int BANK_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS / NUM_BANKS;
    localparam int BANK_AW    = 2 * (COORD_W - 1) + CHAN_W;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_X_RATIO       = 3'd2,
        REG_Y_RATIO       = 3'd3,
        REG_INTERP_MODE   = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_NEAREST  = 1'b0,
        MODE_BILINEAR = 1'b1
    } interp_mode_t;

    typedef enum logic {
        KIND_STORE   = 1'b0,
        KIND_REQUEST = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  source_width;
        logic [SIZE_W-1:0]  source_height;
        logic [RATIO_W-1:0] x_ratio;
        logic [RATIO_W-1:0] y_ratio;
        interp_mode_t       interp_mode;
    } cfg_t;

    // classified operation handed from front to back
    typedef struct packed {
        logic                 write;
        logic [COORD_W-1:0]   x0;
        logic [COORD_W-1:0]   x1;
        logic [COORD_W-1:0]   y0;
        logic [COORD_W-1:0]   y1;
        logic [CHAN_W-1:0]    chan;
        logic [SAMPLE_W-1:0]  sample;
        logic [FRAC_W-1:0]    tx;
        logic [FRAC_W-1:0]    ty;
    } item_t;

endpackage

[src/bilinear_image_resize_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resize_unit: image resampler with on-chip source store
// Stores source samples and returns nearest or bilinear resampled samples.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_       | in        | s_valid / s_ready    | s_kind s_pos_x s_pos_y s_chan s_sample_in
//  m_       | out       | m_valid / m_ready    | m_sample_out
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index cfg_data
//
//  one request per cycle sustained while m_ready holds; the parity-banked store reads
//  all four neighbours at once, so the banks keep up with that rate
//  from s_ accept to m_valid: front stages a and b, queue, bank read, blend, output
//  reset is synchronous, active low; store contents are undefined until written
//  a stall on m_ready fills the back pipeline, the four-entry queue and both front
//  stages before s_ready drops; config writes are always accepted
// ----------------------------------------------------------------------------
module bilinear_image_resize_unit import brz_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // item channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [COORD_W-1:0]   s_pos_x,
    input  logic [COORD_W-1:0]   s_pos_y,
    input  logic [CHAN_W-1:0]    s_chan,
    input  logic [SAMPLE_W-1:0]  s_sample_in,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SAMPLE_W-1:0]  m_sample_out,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RATIO_W-1:0]   cfg_data
);

    cfg_t  cfg_reg;
    logic  front_valid, front_ready;
    item_t front_item;
    logic  head_valid, head_ready;
    item_t head_item;

    // register writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_width  <= SIZE_W'(256);
            cfg_reg.source_height <= SIZE_W'(256);
            cfg_reg.x_ratio       <= RATIO_W'(65536);
            cfg_reg.y_ratio       <= RATIO_W'(65536);
            cfg_reg.interp_mode   <= MODE_BILINEAR;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data[SIZE_W-1:0];
                REG_X_RATIO:       cfg_reg.x_ratio       <= cfg_data;
                REG_Y_RATIO:       cfg_reg.y_ratio       <= cfg_data;
                REG_INTERP_MODE:   cfg_reg.interp_mode   <= interp_mode_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // front: scale coordinates, clamp neighbours, split weights
    brz_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_chan      (s_chan),
        .s_sample_in (s_sample_in),
        .item_valid  (front_valid),
        .item_ready  (front_ready),
        .item        (front_item)
    );

    // decoupling queue keeps store and request order
    brz_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_item   (head_item)
    );

    // back: banked store access and blend
    brz_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head_ready   (head_ready),
        .head         (head_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

endmodule

[src/brz_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brz_front: item front end; stores pass their coordinates through
// Scales destination coordinates, then clamps neighbours and extracts weights.
// ----------------------------------------------------------------------------
module brz_front import brz_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [COORD_W-1:0]  s_pos_x,
    input  logic [COORD_W-1:0]  s_pos_y,
    input  logic [CHAN_W-1:0]   s_chan,
    input  logic [SAMPLE_W-1:0] s_sample_in,
    output logic                item_valid,
    input  logic                item_ready,
    output item_t               item
);

    // stage a: products (2i+1)*ratio
    logic                a_valid_reg;
    logic                a_kind_reg;
    logic [COORD_W-1:0]  a_x_reg, a_y_reg;
    logic [CHAN_W-1:0]   a_chan_reg;
    logic [SAMPLE_W-1:0] a_sample_reg;
    logic [PROD_W-1:0]   a_prod_x_reg, a_prod_y_reg;

    // stage b: classified item
    logic  b_valid_reg;
    item_t b_item_reg, b_item_next;

    logic en_a, en_b;

    assign en_b    = !b_valid_reg || item_ready;
    assign en_a    = !a_valid_reg || en_b;
    assign s_ready = en_a;

    assign item_valid = b_valid_reg;
    assign item       = b_item_reg;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                  input logic [SIZE_W-1:0] maxv);
        if (r == '0)
            return SIZE_W'(1);
        else if (r > maxv)
            return maxv;
        else
            return r;
    endfunction

    function automatic logic [COORD_W-1:0] clamp(input logic signed [INT_W-1:0] v,
                                                input logic [SIZE_W-1:0] size);
        logic signed [INT_W-1:0] lim;
        lim = $signed({{(INT_W-SIZE_W){1'b0}}, size}) - INT_W'(1);
        if (v < 0)
            return '0;
        else if (v > lim)
            return lim[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

    logic [SIZE_W-1:0]       w_eff, h_eff;
    logic signed [POS_W-1:0] fx, fy, rx, ry;
    logic signed [INT_W-1:0] fl_x, fl_y, nr_x, nr_y;

    always_comb begin
        w_eff = eff_size(cfg.source_width, SIZE_W'(MAX_WIDTH));
        h_eff = eff_size(cfg.source_height, SIZE_W'(MAX_HEIGHT));
        fx = $signed({1'b0, 1'b0, a_prod_x_reg[PROD_W-1:1]}) - POS_W'(32768);
        fy = $signed({1'b0, 1'b0, a_prod_y_reg[PROD_W-1:1]}) - POS_W'(32768);
        rx = fx + POS_W'(32768);
        ry = fy + POS_W'(32768);
        fl_x = $signed({fx[POS_W-1], fx[POS_W-1:FRAC_W]});
        fl_y = $signed({fy[POS_W-1], fy[POS_W-1:FRAC_W]});
        // negative positions round to zero or minus one; both clamp to 0, so -1 is used
        nr_x = fx[POS_W-1] ? -INT_W'(1) : $signed({1'b0, rx[POS_W-1:FRAC_W]});
        nr_y = fy[POS_W-1] ? -INT_W'(1) : $signed({1'b0, ry[POS_W-1:FRAC_W]});

        b_item_next.write  = (a_kind_reg == KIND_STORE);
        b_item_next.chan   = a_chan_reg;
        b_item_next.sample = a_sample_reg;
        if (a_kind_reg == KIND_STORE) begin
            b_item_next.x0 = a_x_reg;
            b_item_next.x1 = a_x_reg;
            b_item_next.y0 = a_y_reg;
            b_item_next.y1 = a_y_reg;
            b_item_next.tx = '0;
            b_item_next.ty = '0;
        end else if (cfg.interp_mode == MODE_NEAREST) begin
            b_item_next.x0 = clamp(nr_x, w_eff);
            b_item_next.x1 = b_item_next.x0;
            b_item_next.y0 = clamp(nr_y, h_eff);
            b_item_next.y1 = b_item_next.y0;
            b_item_next.tx = '0;
            b_item_next.ty = '0;
        end else begin
            b_item_next.x0 = clamp(fl_x, w_eff);
            b_item_next.x1 = clamp(fl_x + INT_W'(1), w_eff);
            b_item_next.y0 = clamp(fl_y, h_eff);
            b_item_next.y1 = clamp(fl_y + INT_W'(1), h_eff);
            b_item_next.tx = fx[FRAC_W-1:0];
            b_item_next.ty = fy[FRAC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (en_a)
                a_valid_reg <= s_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a && s_valid) begin
            a_kind_reg   <= s_kind;
            a_x_reg      <= s_pos_x;
            a_y_reg      <= s_pos_y;
            a_chan_reg   <= s_chan;
            a_sample_reg <= s_sample_in;
            a_prod_x_reg <= {s_pos_x, 1'b1} * cfg.x_ratio;
            a_prod_y_reg <= {s_pos_y, 1'b1} * cfg.y_ratio;
        end
        if (en_b && a_valid_reg)
            b_item_reg <= b_item_next;
    end

endmodule

[src/brz_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brz_fifo: short queue between front and back
// Registered circular buffer of classified items.
// ----------------------------------------------------------------------------
module brz_fifo import brz_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t              buf_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               push, pop;

    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = buf_mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            buf_mem[wr_ptr_reg] <= push_item;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_count_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == (FIFO_AW+1)'(FIFO_DEPTH)) |->
        (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

[src/brz_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brz_back: source store and blend pipeline
// Four parity banks, one read per bank per cycle, then a two-step blend.
// ----------------------------------------------------------------------------
module brz_back import brz_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    output logic                head_ready,
    input  item_t               head,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_sample_out
);

    logic en1, en2, en3, pop;

    // stage 1: bank read data
    logic                v1_reg;
    logic [SAMPLE_W-1:0] rd_data_reg [NUM_BANKS];
    logic                x0p_reg, x1p_reg, y0p_reg, y1p_reg;
    logic [FRAC_W-1:0]   tx1_reg, ty1_reg;

    // stage 2: horizontal blend
    logic                v2_reg;
    logic [ROW_W-1:0]    top_reg, bot_reg;
    logic [FRAC_W-1:0]   ty2_reg;

    // stage 3: output register
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_sample_reg;

    assign en3 = !m_valid_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign head_ready = en1;
    assign pop = head_valid && en1;

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
        logic [COORD_W-1:0]  xs, ys;
        logic [BANK_AW-1:0]  addr;
        logic                hit_wr;

        always_comb begin
            xs = (head.x0[0] == 1'(b & 1)) ? head.x0 : head.x1;
            ys = (head.y0[0] == 1'(b >> 1)) ? head.y0 : head.y1;
            addr = {ys[COORD_W-1:1], xs[COORD_W-1:1], head.chan};
            hit_wr = head.write && (head.x0[0] == 1'(b & 1)) &&
                     (head.y0[0] == 1'(b >> 1));
        end

        always_ff @(posedge aclk) begin
            if (pop && hit_wr)
                mem[addr] <= head.sample;
            if (pop && !head.write)
                rd_data_reg[b] <= mem[addr];
        end
    end

    logic [WGT_W-1:0]    wx0, wx1, wy0, wy1;
    logic [SAMPLE_W-1:0] p00, p01, p10, p11;
    logic [BLEND_W-1:0]  blend;

    always_comb begin
        wx1 = {1'b0, tx1_reg};
        wx0 = WGT_W'(1 << FRAC_W) - wx1;
        wy1 = {1'b0, ty2_reg};
        wy0 = WGT_W'(1 << FRAC_W) - wy1;
        p00 = rd_data_reg[{y0p_reg, x0p_reg}];
        p01 = rd_data_reg[{y0p_reg, x1p_reg}];
        p10 = rd_data_reg[{y1p_reg, x0p_reg}];
        p11 = rd_data_reg[{y1p_reg, x1p_reg}];
        // round half up at the q.32 point
        blend = BLEND_W'(top_reg) * BLEND_W'(wy0) + BLEND_W'(bot_reg) * BLEND_W'(wy1)
                + BLEND_W'(1) * BLEND_W'(32'h8000_0000);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1)
                v1_reg <= pop && !head.write;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && !head.write) begin
            x0p_reg <= head.x0[0];
            x1p_reg <= head.x1[0];
            y0p_reg <= head.y0[0];
            y1p_reg <= head.y1[0];
            tx1_reg <= head.tx;
            ty1_reg <= head.ty;
        end
        if (en2 && v1_reg) begin
            top_reg <= ROW_W'(p00) * ROW_W'(wx0) + ROW_W'(p01) * ROW_W'(wx1);
            bot_reg <= ROW_W'(p10) * ROW_W'(wx0) + ROW_W'(p11) * ROW_W'(wx1);
            ty2_reg <= ty1_reg;
        end
        if (en3 && v2_reg)
            m_sample_reg <= blend[2*FRAC_W +: SAMPLE_W];
    end

endmodule

[tb/bilinear_image_resize_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_resize_unit_test: self-checking bench for the resize unit
// Fills small source images, sweeps sizes, ratios and both modes, and checks
// each resampled sample against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module bilinear_image_resize_unit_test;
    import brz_pkg::*;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the source store and registers, and the queue
    // of resampled samples still owed by the block
    // ------------------------------------------------------------------------
    class resize_scoreboard;
        logic [SAMPLE_W-1:0] image [MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS];
        bit                  written [MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS];
        int unsigned         width_reg, height_reg;
        longint              x_ratio, y_ratio;
        interp_mode_t        mode;
        logic [SAMPLE_W-1:0] expected_samples [$];
        int                  errors;

        function void init();
            width_reg = 256;
            height_reg = 256;
            x_ratio = 65536;
            y_ratio = 65536;
            mode = MODE_BILINEAR;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [RATIO_W-1:0] data);
            case (idx)
                REG_SOURCE_WIDTH:  width_reg = data[SIZE_W-1:0];
                REG_SOURCE_HEIGHT: height_reg = data[SIZE_W-1:0];
                REG_X_RATIO:       x_ratio = data;
                REG_Y_RATIO:       y_ratio = data;
                REG_INTERP_MODE:   mode = interp_mode_t'(data[0]);
                default: ;
            endcase
        endfunction

        function int unsigned eff_size(int unsigned r, int unsigned maxv);
            if (r == 0) return 1;
            if (r > maxv) return maxv;
            return r;
        endfunction

        function int unsigned addr(int unsigned x, int unsigned y, int unsigned c);
            return (y * MAX_WIDTH + x) * MAX_CHANNELS + c;
        endfunction

        function int unsigned clamp(longint v, int unsigned size);
            if (v < 0) return 0;
            if (v > longint'(size) - 1) return size - 1;
            return int'(v);
        endfunction

        // source position in signed Q.16: floor((2d+1)*ratio/2) - 0.5
        function longint src_pos(int unsigned d, longint ratio);
            return (((2 * longint'(d)) + 1) * ratio >>> 1) - 32768;
        endfunction

        // neighbor coordinates and weights for a destination pixel
        function void locate(int unsigned px, int unsigned py,
                             output int unsigned x0, output int unsigned x1,
                             output int unsigned y0, output int unsigned y1,
                             output longint tx, output longint ty);
            int unsigned w, h;
            longint fx, fy, lx, ly;
            w = eff_size(width_reg, MAX_WIDTH);
            h = eff_size(height_reg, MAX_HEIGHT);
            fx = src_pos(px, x_ratio);
            fy = src_pos(py, y_ratio);
            if (mode == MODE_NEAREST) begin
                // round half away from zero
                lx = (fx >= 0) ? ((fx + 32768) >>> 16) : -((-fx + 32768) >>> 16);
                ly = (fy >= 0) ? ((fy + 32768) >>> 16) : -((-fy + 32768) >>> 16);
                x0 = clamp(lx, w);
                x1 = x0;
                y0 = clamp(ly, h);
                y1 = y0;
                tx = 0;
                ty = 0;
            end else begin
                lx = fx >>> 16;
                ly = fy >>> 16;
                tx = fx - (lx <<< 16);
                ty = fy - (ly <<< 16);
                x0 = clamp(lx, w);
                x1 = clamp(lx + 1, w);
                y0 = clamp(ly, h);
                y1 = clamp(ly + 1, h);
            end
        endfunction

        function bit readable(int unsigned px, int unsigned py, int unsigned c);
            int unsigned x0, x1, y0, y1;
            longint tx, ty;
            locate(px, py, x0, x1, y0, y1, tx, ty);
            return written[addr(x0, y0, c)] && written[addr(x1, y0, c)] &&
                   written[addr(x0, y1, c)] && written[addr(x1, y1, c)];
        endfunction

        function void note_input(item_kind_t kind, int unsigned px, int unsigned py,
                                 int unsigned c, logic [SAMPLE_W-1:0] s);
            int unsigned x0, x1, y0, y1;
            longint tx, ty, top, bot, v;
            if (kind == KIND_STORE) begin
                image[addr(px, py, c)] = s;
                written[addr(px, py, c)] = 1'b1;
                return;
            end
            locate(px, py, x0, x1, y0, y1, tx, ty);
            top = image[addr(x0, y0, c)] * (65536 - tx) + image[addr(x1, y0, c)] * tx;
            bot = image[addr(x0, y1, c)] * (65536 - tx) + image[addr(x1, y1, c)] * tx;
            v = top * (65536 - ty) + bot * ty;
            expected_samples.push_back(SAMPLE_W'((v + 64'h8000_0000) >>> 32));
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        function int pending();
            return expected_samples.size();
        endfunction

        task check_result(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0) begin
                report($sformatf("unexpected sample_out %0d", got));
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want)
                report($sformatf("sample_out %0d, expected %0d", got, want));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_kind;
    logic [COORD_W-1:0]   s_pos_x;
    logic [COORD_W-1:0]   s_pos_y;
    logic [CHAN_W-1:0]    s_chan;
    logic [SAMPLE_W-1:0]  s_sample_in;
    logic                 m_valid;
    logic                 m_ready;
    logic [SAMPLE_W-1:0]  m_sample_out;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATIO_W-1:0]   cfg_data;

    resize_scoreboard sb;
    bit tx_burst;         // sender runs with no gaps
    bit rx_burst;         // receiver never stalls
    int rx_wait;

    bilinear_image_resize_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_chan(s_chan),
        .s_sample_in(s_sample_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_sample_out(m_sample_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver: random stall before each result, none while rx_burst is set
    always @(negedge aclk) begin
        if (rx_wait > 0) begin
            m_ready = 1'b0;
            rx_wait--;
        end else begin
            m_ready = 1'b1;
        end
    end

    // sample results at the rising edge, before the block updates
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_sample_out);
            rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
        end
    end

    // one item on the item channel; entered and left just after a falling edge
    task send_item(item_kind_t kind, int unsigned px, int unsigned py,
                   int unsigned c, logic [SAMPLE_W-1:0] s);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_kind = kind;
        s_pos_x = px;
        s_pos_y = py;
        s_chan = c;
        s_sample_in = s;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(kind, px, py, c, s);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task write_reg(cfg_reg_t idx, logic [RATIO_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // sender pauses until every owed result is out, then lets stores drain
    task wait_idle();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    // size registers get random junk above their nine bits, the mode register above bit 0
    task configure(int unsigned w, int unsigned h, longint xr, longint yr,
                   interp_mode_t md);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, RATIO_W'({$urandom, w[SIZE_W-1:0]}));
        write_reg(REG_SOURCE_HEIGHT, RATIO_W'({$urandom, h[SIZE_W-1:0]}));
        write_reg(REG_X_RATIO, RATIO_W'(xr));
        write_reg(REG_Y_RATIO, RATIO_W'(yr));
        write_reg(REG_INTERP_MODE, RATIO_W'({$urandom, md}));
    endtask

    function longint pick_ratio();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 33554431);
            1: return $urandom_range(16384, 262144);
            2: return 65536 >> $urandom_range(0, 2);
            default: return 65536 << $urandom_range(0, 3);
        endcase
    endfunction

    // fill the whole image for channel 0 and as many more as fit a small budget
    task fill_image();
        int unsigned w, h, nch;
        w = sb.eff_size(sb.width_reg, MAX_WIDTH);
        h = sb.eff_size(sb.height_reg, MAX_HEIGHT);
        nch = 64 / (w * h);
        if (nch < 1) nch = 1;
        if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
        for (int unsigned c = 0; c < nch; c++)
            for (int unsigned y = 0; y < h; y++)
                for (int unsigned x = 0; x < w; x++)
                    send_item(KIND_STORE, x, y, c, $urandom_range(0, 255));
    endtask

    // mostly requests that land on written samples, some stores
    task random_items(int n);
        int unsigned w, h, limx, limy, px, py, c;
        bit ok;
        w = sb.eff_size(sb.width_reg, MAX_WIDTH);
        h = sb.eff_size(sb.height_reg, MAX_HEIGHT);
        limx = (sb.x_ratio == 0) ? 255 : ((longint'(w) << 16) / sb.x_ratio) + 1;
        limy = (sb.y_ratio == 0) ? 255 : ((longint'(h) << 16) / sb.y_ratio) + 1;
        if (limx > 255) limx = 255;
        if (limy > 255) limy = 255;
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(KIND_STORE, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 3), $urandom_range(0, 255));
                else
                    send_item(KIND_STORE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                              $urandom_range(0, 3), $urandom_range(0, 255));
            end else begin
                ok = 1'b0;
                for (int t = 0; t < 16 && !ok; t++) begin
                    px = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, limx);
                    py = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, limy);
                    c = $urandom_range(0, 3);
                    ok = sb.readable(px, py, c);
                end
                // channel 0 always covers the image
                if (!ok) c = 0;
                send_item(KIND_REQUEST, px, py, c, $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.init();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_STORE;
        s_pos_x = '0;
        s_pos_y = '0;
        s_chan = '0;
        s_sample_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SOURCE_WIDTH;
        cfg_data = '0;
        m_ready = 1'b0;
        rx_wait = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset settings, a 3x3 corner patch and the far 2x2 corner
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                send_item(KIND_STORE, x, y, 0, (x + y) * 100 + (x == 2 ? 55 : 0));
        for (int y = 254; y < 256; y++)
            for (int x = 254; x < 256; x++) begin
                send_item(KIND_STORE, x, y, 3, 255 - (x - 254) * 40);
                send_item(KIND_STORE, x, y, 0, (y - 254) * 70);
            end
        send_item(KIND_REQUEST, 0, 0, 0, 255);      // position 0 maps exactly onto sample 0
        send_item(KIND_REQUEST, 1, 1, 0, 0);
        send_item(KIND_REQUEST, 255, 255, 3, 0);    // far edge clamps
        send_item(KIND_REQUEST, 255, 255, 0, 0);
        configure(256, 256, 98304, 32768, MODE_BILINEAR);
        send_item(KIND_REQUEST, 1, 2, 0, 0);        // quarter-pixel weights
        send_item(KIND_REQUEST, 0, 3, 0, 0);
        configure(256, 256, 98304, 32768, MODE_NEAREST);
        send_item(KIND_REQUEST, 1, 2, 0, 0);        // rounds to the nearest sample
        send_item(KIND_REQUEST, 0, 0, 0, 0);

        // random phases, extremes first
        for (int p = 0; p < 10; p++) begin
            tx_burst = (p % 4 == 3);
            rx_burst = (p % 5 == 4);
            case (p)
                0: configure(0, 0, 0, 0, MODE_BILINEAR);                // zero sizes and ratios
                1: configure(511, 1, 16777216, 65536, MODE_NEAREST);    // width saturates
                2: configure(1, 256, 33554431, 256, MODE_BILINEAR);     // largest x ratio
                3: configure(256, 1, pick_ratio(), 0, MODE_BILINEAR);
                4: configure(2, 2, 33554431, 16777216, MODE_NEAREST);
                default: configure($urandom_range(1, 12), $urandom_range(1, 12),
                                   pick_ratio(), pick_ratio(),
                                   interp_mode_t'($urandom_range(0, 1)));
            endcase
            fill_image();
            random_items(40);
        end

        tx_burst = 1'b0;
        rx_burst = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (sb.errors == 0)
            $display("[bilinear_image_resize_unit] OK");
        else
            $display("[bilinear_image_resize_unit] ERROR");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #20ms;
        $display("[bilinear_image_resize_unit] ERROR");
        $finish;
    end

endmodule
